### rtl/core/cbi_pkg.sv
// Shared types, constants and rate tables of the convolutional byte interleaver.
package cbi_pkg;

   // Field widths
   localparam int DATA_W      = 8;
   localparam int EXTRA_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TX_MODE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BITS_PER_SYMBOL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_CODE       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_COUNT   = 3'd3;

   // Register reset values
   localparam logic [1:0] RST_TX_MODE         = 2'd1;
   localparam logic [2:0] RST_BITS_PER_SYMBOL = 3'd2;
   localparam logic [2:0] RST_RATE_CODE       = 3'd0;
   localparam logic [3:0] RST_SEGMENT_COUNT   = 4'd1;

   // Code rate codes
   localparam logic [2:0] RATE_1_2 = 3'd0;
   localparam logic [2:0] RATE_2_3 = 3'd1;
   localparam logic [2:0] RATE_3_4 = 3'd2;
   localparam logic [2:0] RATE_5_6 = 3'd3;
   localparam logic [2:0] RATE_7_8 = 3'd4;

   // Packet geometry: 96 carriers = 3 << 5 in mode 1, and the divide by 8 sits in the rate denominator
   localparam int PACKET_BYTES       = 204;
   localparam int PACKET_OFFSET      = 11;
   localparam int CARRIER_FACTOR     = 3;
   localparam int CARRIER_SHIFT_BASE = 4;

   // Extra delay arithmetic
   localparam int PROD_W     = 12;
   localparam int DIV_W      = 22;
   localparam int DEN_W      = 7;
   localparam int DIV_CNT_W  = 5;
   localparam int RATE_NUM_W = 5;

   // Output queue
   localparam int OUT_FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W     = 2;
   localparam int FIFO_CNT_W     = 3;

   typedef struct packed {
      logic [1:0] tx_mode;
      logic [2:0] bits_per_symbol;
      logic [2:0] rate_code;
      logic [3:0] segment_count;
   } cbi_cfg_type;

   typedef struct packed {
      logic               busy;
      logic [EXTRA_W-1:0] base_delay;
   } cbi_calc_status_type;

   // Rate numerator times the carrier factor; unknown rates give zero
   function automatic logic [RATE_NUM_W-1:0] rate_num3(input logic [2:0] code);
      logic [RATE_NUM_W-1:0] val;
      unique case (code)
         RATE_1_2: val = RATE_NUM_W'(1 * CARRIER_FACTOR);
         RATE_2_3: val = RATE_NUM_W'(2 * CARRIER_FACTOR);
         RATE_3_4: val = RATE_NUM_W'(3 * CARRIER_FACTOR);
         RATE_5_6: val = RATE_NUM_W'(5 * CARRIER_FACTOR);
         RATE_7_8: val = RATE_NUM_W'(7 * CARRIER_FACTOR);
         default:  val = '0;
      endcase
      return val;
   endfunction

   // Rate denominator times 8; unknown rates get a harmless nonzero divisor
   function automatic logic [DEN_W-1:0] rate_den8(input logic [2:0] code);
      logic [DEN_W-1:0] val;
      unique case (code)
         RATE_1_2: val = DEN_W'(2 * 8);
         RATE_2_3: val = DEN_W'(3 * 8);
         RATE_3_4: val = DEN_W'(4 * 8);
         RATE_5_6: val = DEN_W'(6 * 8);
         RATE_7_8: val = DEN_W'(8 * 8);
         default:  val = DEN_W'(2 * 8);
      endcase
      return val;
   endfunction

endpackage

### rtl/core/cbi_req_if.sv
// Input byte channel of the interleaver.
interface cbi_req_if;
   import cbi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/core/cbi_rsp_if.sv
// Result byte channel of the interleaver.
interface cbi_rsp_if;
   import cbi_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

### rtl/core/cbi_csr_if.sv
// Register write channel of the interleaver.
interface cbi_csr_if;
   import cbi_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

### rtl/core/convolutional_byte_interleaver.sv
// Convolutional byte interleaver: top level with commutator, ring pointers and delay memory.
//
// One byte in, one byte out: byte n goes to branch n mod BRANCHES and comes back out of
// that branch delayed by E + BRANCH_STEP*b visits (capped at BRANCH_DEPTH-1), where E is
// derived from tx_mode, bits_per_symbol, rate_code and segment_count. Bytes that were never
// written since the last configuration write read back as zero. The block takes one byte
// every clock cycle while req ready is high; an accepted beat passes the result stage
// register and then the output queue on its way to the result channel, and the four-deep
// output queue absorbs stalls on the result side. Each byte costs one write and one read of
// the single delay RAM (BRANCHES*2^clog2(BRANCH_DEPTH) bytes), and that port pair sets the
// rate. There is no clearing sweep of the RAM: a fill counter per branch marks the slots
// that hold real data. After reset and after every configuration write, E is recomputed:
// a serial divider applies the code rate and a reciprocal multiply splits the bytes over
// the branches. req ready stays low meanwhile and also while a register beat is offered;
// register writes are taken at any time, and each configuration write also rewinds every
// branch while the commutator keeps its position.
module convolutional_byte_interleaver #(
   parameter int BRANCHES     = 12,
   parameter int BRANCH_STEP  = 17,
   parameter int BRANCH_DEPTH = 65536
) (
   input  logic    clock,
   input  logic    reset,
   cbi_req_if.sink   req_chan,
   cbi_rsp_if.source rsp_chan,
   cbi_csr_if.sink   csr_chan
);
   import cbi_pkg::*;

   localparam int BR_W      = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;
   localparam int PTR_W     = $clog2(BRANCH_DEPTH);
   localparam int DSUM_W    = EXTRA_W + 1;
   localparam int RAM_DEPTH = BRANCHES * (2 ** PTR_W);
   localparam int RAM_AW    = BR_W + PTR_W;
   localparam int SLOT_W    = FIFO_CNT_W + 1;

   localparam logic [DSUM_W-1:0] DELAY_MAX   = DSUM_W'(BRANCH_DEPTH - 1);
   localparam logic [BR_W-1:0]   LAST_BRANCH = BR_W'(BRANCHES - 1);

   // Configuration
   cbi_cfg_type         cfg_ff, cfg_in;
   logic                cfg_hit;
   logic                csr_fire;
   cbi_calc_status_type calc_status;

   // Commutator and branch rings
   logic [BR_W-1:0]  branch_ff;
   logic [PTR_W-1:0] ptr_ff  [BRANCHES];
   logic [PTR_W-1:0] fill_ff [BRANCHES];

   logic              accept;
   logic [PTR_W-1:0]  cur_ptr, cur_fill;
   logic [DSUM_W-1:0] step_off, delay_sum;
   logic [PTR_W-1:0]  delay;
   logic [PTR_W-1:0]  ptr_eff, ptr_next, fill_next;
   logic              filled;

   // Result stage
   logic              s1_valid_ff;
   logic              s1_zero_ff;
   logic              s1_bypass_ff;
   logic [DATA_W-1:0] s1_byte_ff;
   logic [DATA_W-1:0] ram_rd_data;
   logic [DATA_W-1:0] s1_result;
   logic [FIFO_CNT_W-1:0] fifo_count;

   // Decode register writes
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid & csr_chan.ready;

   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b0;
      if (csr_fire) begin
         unique case (csr_chan.reg_index)
            REG_TX_MODE: begin
               cfg_in.tx_mode = csr_chan.write_data[1:0];
               cfg_hit        = 1'b1;
            end
            REG_BITS_PER_SYMBOL: begin
               cfg_in.bits_per_symbol = csr_chan.write_data[2:0];
               cfg_hit                = 1'b1;
            end
            REG_RATE_CODE: begin
               cfg_in.rate_code = csr_chan.write_data[2:0];
               cfg_hit          = 1'b1;
            end
            REG_SEGMENT_COUNT: begin
               cfg_in.segment_count = csr_chan.write_data[3:0];
               cfg_hit              = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_mode         <= RST_TX_MODE;
         cfg_ff.bits_per_symbol <= RST_BITS_PER_SYMBOL;
         cfg_ff.rate_code       <= RST_RATE_CODE;
         cfg_ff.segment_count   <= RST_SEGMENT_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbi_delay_calc #(
      .BRANCHES (BRANCHES)
   ) u_delay_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (cfg_hit),
      .cfg    (cfg_ff),
      .status (calc_status)
   );

   // Take a beat only when the delay is not being recomputed, no register beat is offered
   // and the queue has room for everything in flight
   assign req_chan.ready = !calc_status.busy && !csr_chan.valid &&
                           ((SLOT_W'(fifo_count) + SLOT_W'(s1_valid_ff)) <
                            SLOT_W'(OUT_FIFO_DEPTH));
   assign accept = req_chan.valid & req_chan.ready;

   // Branch delay and ring positions for the current branch
   always_comb begin
      cur_ptr   = ptr_ff[branch_ff];
      cur_fill  = fill_ff[branch_ff];
      step_off  = DSUM_W'(BRANCH_STEP) * DSUM_W'(branch_ff);
      delay_sum = DSUM_W'(calc_status.base_delay) + step_off;
      delay     = (delay_sum > DELAY_MAX) ? DELAY_MAX[PTR_W-1:0] : delay_sum[PTR_W-1:0];
      ptr_eff   = (cur_ptr > delay) ? '0 : cur_ptr;
      ptr_next  = (ptr_eff >= delay) ? '0 : ptr_eff + 1'b1;
      filled    = (cur_fill >= delay);
      fill_next = filled ? cur_fill : cur_fill + 1'b1;
   end

   // Advance the commutator; rewind all rings on a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         branch_ff <= '0;
         for (int i = 0; i < BRANCHES; i++) begin
            ptr_ff[i]  <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cfg_hit) begin
         for (int i = 0; i < BRANCHES; i++) begin
            ptr_ff[i]  <= '0;
            fill_ff[i] <= '0;
         end
      end else if (accept) begin
         ptr_ff[branch_ff]  <= ptr_next;
         fill_ff[branch_ff] <= fill_next;
         branch_ff          <= (branch_ff == LAST_BRANCH) ? '0 : branch_ff + 1'b1;
      end
   end

   // Delay memory: write the new byte, read the oldest byte of the ring
   cbi_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (RAM_AW'({branch_ff, ptr_eff})),
      .wr_data (req_chan.data_byte),
      .rd_en   (accept),
      .rd_addr (RAM_AW'({branch_ff, ptr_next})),
      .rd_data (ram_rd_data)
   );

   // Track the beat alongside the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_zero_ff   <= !filled;
         s1_bypass_ff <= (delay == '0);
         s1_byte_ff   <= req_chan.data_byte;
      end
   end

   // Pick unwritten-slot zero, zero-delay bypass or the RAM byte
   always_comb begin
      if (s1_zero_ff) begin
         s1_result = '0;
      end else if (s1_bypass_ff) begin
         s1_result = s1_byte_ff;
      end else begin
         s1_result = ram_rd_data;
      end
   end

   cbi_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_result),
      .count     (fifo_count),
      .rsp_chan  (rsp_chan)
   );

   // Fill counter never passes the ring length of its branch
   a_fill_in_ring: assert property (@(posedge clock) disable iff (reset)
      accept |-> cur_fill <= delay)
      else $error("branch fill count beyond its delay");

   // Ring pointer stays inside the ring between register writes
   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      accept |-> cur_ptr <= delay)
      else $error("branch pointer beyond its delay");

   // A register write restarts the delay computation and blocks input
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> calc_status.busy && !req_chan.ready)
      else $error("input open while the delay is recomputed");

   // A bypassed beat always comes from a filled ring
   a_bypass_filled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_bypass_ff) |-> !s1_zero_ff)
      else $error("zero-delay beat flagged as unwritten");

endmodule

### rtl/core/cbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cbi_delay_calc.sv
// Sequencer that derives the extra delay from the configuration with a serial divider.
module cbi_delay_calc #(
   parameter int BRANCHES = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  cbi_pkg::cbi_cfg_type         cfg,
   output cbi_pkg::cbi_calc_status_type status
);
   import cbi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROD   = 3'd1;
   localparam logic [2:0] ST_RATE   = 3'd2;
   localparam logic [2:0] ST_LOAD_Q = 3'd3;
   localparam logic [2:0] ST_DIV_Q  = 3'd4;
   localparam logic [2:0] ST_SCALE  = 3'd5;
   localparam logic [2:0] ST_DIV_E  = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   localparam logic [DIV_W-1:0] EXTRA_MAX = DIV_W'((1 << EXTRA_W) - 1);

   // Rounded-up reciprocal of the branch count, exact for every dividend below 2^DIV_W
   localparam int RECIP_L = $clog2(BRANCHES);
   localparam int RECIP_S = DIV_W + RECIP_L;
   localparam int RECIP_W = DIV_W + 1;
   localparam int MUL_W   = DIV_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_S) + 64'(BRANCHES) - 64'd1) / 64'(BRANCHES);
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

   logic [2:0]           state_ff, state_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [EXTRA_W-1:0]   extra_ff, extra_in;

   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       rem_diff;
   logic                 sub_ok;
   logic [DEN_W-1:0]     rem_step;
   logic [DIV_W-1:0]     quo_step;
   logic [DIV_W-1:0]     num_val;
   logic [DIV_W-1:0]     scaled;
   logic [MUL_W-1:0]     recip_prod;
   logic [DIV_W-1:0]     recip_quo;

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      sub_ok   = (rem_sh >= {1'b0, den_ff});
      rem_step = sub_ok ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_step = {quo_ff[DIV_W-2:0], sub_ok};
   end

   // Dividend for the packet count, the byte count over all branches and its split
   always_comb begin
      if (cfg.tx_mode == 2'd0) begin
         num_val = '0;
      end else begin
         num_val = DIV_W'(prod_ff) << (CARRIER_SHIFT_BASE + int'(cfg.tx_mode));
      end
      scaled     = (quo_ff - DIV_W'(PACKET_OFFSET)) * DIV_W'(PACKET_BYTES);
      recip_prod = MUL_W'(quo_ff) * MUL_W'(RECIP_M);
      recip_quo  = DIV_W'(recip_prod >> RECIP_S);
   end

   // Sequence the products, the rate division and the branch split
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      extra_in = extra_ff;
      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_PROD: begin
            prod_in  = PROD_W'(cfg.segment_count) * PROD_W'(cfg.bits_per_symbol);
            state_in = ST_RATE;
         end
         ST_RATE: begin
            prod_in  = prod_ff * PROD_W'(rate_num3(cfg.rate_code));
            state_in = ST_LOAD_Q;
         end
         ST_LOAD_Q: begin
            quo_in   = num_val;
            rem_in   = '0;
            den_in   = rate_den8(cfg.rate_code);
            cnt_in   = DIV_CNT_W'(DIV_W - 1);
            state_in = ST_DIV_Q;
         end
         ST_DIV_Q: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (quo_ff <= DIV_W'(PACKET_OFFSET)) begin
               extra_in = '0;
               state_in = ST_IDLE;
            end else begin
               quo_in   = scaled;
               state_in = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            quo_in   = recip_quo;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            extra_in = (quo_ff > EXTRA_MAX) ? '1 : quo_ff[EXTRA_W-1:0];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Restart on every configuration register write
      if (start) begin
         state_in = ST_PROD;
      end
   end

   // Control state restarts the computation out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PROD;
         extra_ff <= '0;
      end else begin
         state_ff <= state_in;
         extra_ff <= extra_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign status.busy       = (state_ff != ST_IDLE);
   assign status.base_delay = extra_ff;

   // Divisor is never zero while dividing
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_Q) |-> den_ff != '0)
      else $error("divider running with a zero divisor");

endmodule

### rtl/core/cbi_out_fifo.sv
// Small register queue that holds finished bytes for the result channel.
module cbi_out_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [cbi_pkg::DATA_W-1:0]     push_data,
   output logic [cbi_pkg::FIFO_CNT_W-1:0] count,
   cbi_rsp_if.source                      rsp_chan
);
   import cbi_pkg::*;

   logic [DATA_W-1:0]     entries_ff [OUT_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  pop;

   assign pop = rsp_chan.valid & rsp_chan.ready;

   // Store a beat at the write pointer
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   assign rsp_chan.valid    = (count_ff != '0);
   assign rsp_chan.out_byte = entries_ff[rd_ptr_ff];
   assign count             = count_ff;

   // Credit on the input side keeps the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != FIFO_CNT_W'(OUT_FIFO_DEPTH))
      else $error("output queue written while full");

endmodule
